// ===== design/lrsr_pkg.sv =====
// shared types and constants of the lr shift-reduce parse engine
package lrsr_pkg;

    typedef enum logic [2:0] {
        K_LOAD_ACT  = 3'd0,
        K_LOAD_GOTO = 3'd1,
        K_LOAD_PROD = 3'd2,
        K_TOKEN     = 3'd3,
        K_RESTART   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        A_ERROR  = 2'd0,
        A_SHIFT  = 2'd1,
        A_REDUCE = 2'd2,
        A_ACCEPT = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        ST_SHIFT    = 3'd0,
        ST_REDUCE   = 3'd1,
        ST_ACCEPT   = 3'd2,
        ST_ACT_ERR  = 3'd3,
        ST_GOTO_ERR = 3'd4,
        ST_HALTED   = 3'd5,
        ST_OVERFLOW = 3'd6,
        ST_LIMIT    = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HALT,
        S_ACT_RD,
        S_ACT,
        S_PROD_RD,
        S_PROD,
        S_POP_RD,
        S_POP,
        S_GOTO_RD,
        S_GOTO
    } t_state;

    localparam logic [5:0] CHAIN_LIMIT = 6'd63;

    typedef struct packed {
        logic       act_we;
        logic       goto_we;
        logic       prod_we;
        logic [5:0] row;
        logic [3:0] col;
        t_act       code;
        logic [5:0] target;
        logic       gvalid;
        logic [4:0] prod_num;
        logic [3:0] lhs;
        logic [3:0] len;
    } t_tbl_load;

endpackage

// ===== design/lrsr_ram.sv =====
// generic single write port ram with registered read
module lrsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lrsr_tables.sv =====
// action, goto and production tables with the clearing sweep after reset
module lrsr_tables #(
    parameter int NUM_STATES      = 64,
    parameter int NUM_SYMBOLS     = 16,
    parameter int NUM_PRODUCTIONS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrsr_pkg::t_tbl_load i_load,
    input  logic [5:0]          i_act_top,
    input  logic [3:0]          i_act_sym,
    input  logic [5:0]          i_goto_top,
    input  logic [3:0]          i_goto_sym,
    input  logic [5:0]          i_prod_sel,
    output logic [7:0]          o_act_entry,
    output logic [6:0]          o_goto_entry,
    output logic [7:0]          o_prod_entry,
    output logic                o_busy
);
    import lrsr_pkg::*;

    localparam int TA_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TA_W     = $clog2(TA_DEPTH);
    localparam int PAW      = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;

    function automatic logic [TA_W-1:0] tbl_addr(input logic [5:0] top, input logic [3:0] sym);
        logic [TA_W-1:0] s;
        s = (int'(sym) < NUM_SYMBOLS) ? TA_W'(sym) : '0;
        return TA_W'(TA_W'(top) * TA_W'(NUM_SYMBOLS)) + s;
    endfunction

    logic            r_clr_busy;
    logic [TA_W-1:0] r_clr_addr;
    logic            load_in_range;
    logic            act_we, goto_we, prod_we;
    logic [TA_W-1:0] tbl_waddr;
    logic [7:0]      act_wdata;
    logic [6:0]      goto_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == TA_W'(TA_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign load_in_range = (int'(i_load.row) < NUM_STATES) && (int'(i_load.col) < NUM_SYMBOLS);
    assign act_we     = r_clr_busy || (i_load.act_we && load_in_range);
    assign goto_we    = r_clr_busy || (i_load.goto_we && load_in_range);
    assign prod_we    = i_load.prod_we && (int'(i_load.prod_num) < NUM_PRODUCTIONS);
    assign tbl_waddr  = r_clr_busy ? r_clr_addr : tbl_addr(i_load.row, i_load.col);
    assign act_wdata  = r_clr_busy ? 8'd0 : {i_load.code, i_load.target};
    assign goto_wdata = r_clr_busy ? 7'd0 : {i_load.gvalid, i_load.target};

    lrsr_ram #(.WIDTH(8), .DEPTH(TA_DEPTH)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (tbl_waddr),
        .i_wdata (act_wdata),
        .i_raddr (tbl_addr(i_act_top, i_act_sym)),
        .o_rdata (o_act_entry)
    );

    lrsr_ram #(.WIDTH(7), .DEPTH(TA_DEPTH)) u_goto_ram (
        .i_clk   (i_clk),
        .i_we    (goto_we),
        .i_waddr (tbl_waddr),
        .i_wdata (goto_wdata),
        .i_raddr (tbl_addr(i_goto_top, i_goto_sym)),
        .o_rdata (o_goto_entry)
    );

    lrsr_ram #(.WIDTH(8), .DEPTH(NUM_PRODUCTIONS)) u_prod_ram (
        .i_clk   (i_clk),
        .i_we    (prod_we),
        .i_waddr (PAW'(i_load.prod_num)),
        .i_wdata ({i_load.lhs, i_load.len}),
        .i_raddr (PAW'(i_prod_sel)),
        .o_rdata (o_prod_entry)
    );

    assign o_busy = r_clr_busy;

endmodule

// ===== design/lr_shift_reduce_parse_engine.sv =====
// lr shift-reduce parse engine top level: parse sequencer and state stack
// loads and restarts give no word
// a token ending in shift, accept or action error gives its word through S_ACT_RD, S_ACT and the output register
// each reduce runs the action, production, stack and goto reads in turn
// the next token is taken once the last word of a run sits in the output register
// after reset the action and goto tables are swept clear, input stalled
module lr_shift_reduce_parse_engine #(
    parameter int NUM_STATES      = 64,
    parameter int NUM_SYMBOLS     = 16,
    parameter int NUM_PRODUCTIONS = 32,
    parameter int STACK_DEPTH     = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_kind,
    input  logic [5:0] i_row_state,
    input  logic [3:0] i_column_symbol,
    input  logic [1:0] i_action_code,
    input  logic [5:0] i_entry_target,
    input  logic       i_goto_valid,
    input  logic [4:0] i_prod_number,
    input  logic [3:0] i_prod_lhs,
    input  logic [3:0] i_prod_length,
    input  logic [3:0] i_token,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [4:0] o_reduced_production,
    output logic [5:0] o_new_top_state,
    output logic [6:0] o_stack_depth,
    output logic       o_last
);
    import lrsr_pkg::*;

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int CMP_W  = (SP_W > 4) ? SP_W : 4;
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    t_state          r_state, n_state;
    logic [5:0]      r_top, n_top;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [3:0]      r_tok, n_tok;
    logic [5:0]      r_tgt, n_tgt;
    logic [3:0]      r_lhs, n_lhs;
    logic [5:0]      r_reduces, n_reduces;
    logic            r_halted, n_halted;

    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic [4:0]      r_out_prod, n_out_prod;
    logic [5:0]      r_out_top, n_out_top;
    logic [6:0]      r_out_depth, n_out_depth;
    logic            r_out_last, n_out_last;

    logic            in_acc;
    logic            slot_free;
    logic            emit;
    t_status         emit_status;
    logic            emit_last;
    logic            emit_prod;
    t_kind           kind;

    t_tbl_load       tbl_load;
    logic [7:0]      act_entry;
    logic [6:0]      goto_entry;
    logic [7:0]      prod_entry;
    logic            tbl_busy;
    t_act            act_code;
    logic [5:0]      act_tgt;

    logic            st_we;
    logic [5:0]      st_wdata;
    logic [5:0]      st_rdata;
    logic [SP_W-1:0] sp_m1;

    assign kind      = t_kind'(i_kind);
    assign o_stall   = (r_state != S_IDLE) || tbl_busy;
    assign in_acc    = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;
    assign act_code  = t_act'(act_entry[7:6]);
    assign act_tgt   = act_entry[5:0];
    assign sp_m1     = r_sp - 1'b1;

    always_comb begin
        tbl_load          = '0;
        tbl_load.row      = i_row_state;
        tbl_load.col      = i_column_symbol;
        tbl_load.code     = t_act'(i_action_code);
        tbl_load.target   = i_entry_target;
        tbl_load.gvalid   = i_goto_valid;
        tbl_load.prod_num = i_prod_number;
        tbl_load.lhs      = i_prod_lhs;
        tbl_load.len      = i_prod_length;
        tbl_load.act_we   = in_acc && (kind == K_LOAD_ACT);
        tbl_load.goto_we  = in_acc && (kind == K_LOAD_GOTO);
        tbl_load.prod_we  = in_acc && (kind == K_LOAD_PROD);
    end

    lrsr_tables #(
        .NUM_STATES      (NUM_STATES),
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .NUM_PRODUCTIONS (NUM_PRODUCTIONS)
    ) u_tables (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (tbl_load),
        .i_act_top    (r_top),
        .i_act_sym    (r_tok),
        .i_goto_top   (r_top),
        .i_goto_sym   (r_lhs),
        .i_prod_sel   (r_tgt),
        .o_act_entry  (act_entry),
        .o_goto_entry (goto_entry),
        .o_prod_entry (prod_entry),
        .o_busy       (tbl_busy)
    );

    lrsr_ram #(.WIDTH(6), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_sp[STK_AW-1:0]),
        .i_wdata (st_wdata),
        .i_raddr (sp_m1[STK_AW-1:0]),
        .o_rdata (st_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_sp        <= SP_W'(1);
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_sp        <= n_sp;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok        <= n_tok;
        r_tgt        <= n_tgt;
        r_lhs        <= n_lhs;
        r_reduces    <= n_reduces;
        r_out_status <= n_out_status;
        r_out_prod   <= n_out_prod;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_sp        = r_sp;
        n_tok       = r_tok;
        n_tgt       = r_tgt;
        n_lhs       = r_lhs;
        n_reduces   = r_reduces;
        n_halted    = r_halted;
        emit        = 1'b0;
        emit_status = ST_SHIFT;
        emit_last   = 1'b1;
        emit_prod   = 1'b0;
        st_we       = 1'b0;
        st_wdata    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (kind)
                        K_TOKEN: begin
                            n_tok     = i_token;
                            n_reduces = '0;
                            n_state   = r_halted ? S_HALT : S_ACT_RD;
                        end
                        K_RESTART: begin
                            n_top    = '0;
                            n_sp     = SP_W'(1);
                            n_halted = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HALT: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    emit_status = ST_HALTED;
                    n_state     = S_IDLE;
                end
            end
            S_ACT_RD: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                if (int'(r_tok) >= NUM_SYMBOLS) begin
                    emit_status = ST_ACT_ERR;
                end else begin
                    unique case (act_code)
                        A_ERROR:  emit_status = ST_ACT_ERR;
                        A_ACCEPT: emit_status = ST_ACCEPT;
                        A_SHIFT: begin
                            if (int'(act_tgt) >= NUM_STATES) begin
                                emit_status = ST_ACT_ERR;
                            end else if (r_sp == SP_FULL) begin
                                emit_status = ST_OVERFLOW;
                            end else begin
                                emit_status = ST_SHIFT;
                            end
                        end
                        A_REDUCE: begin
                            if (r_reduces == CHAIN_LIMIT) begin
                                emit_status = ST_LIMIT;
                            end else if (int'(act_tgt) >= NUM_PRODUCTIONS) begin
                                emit_status = ST_ACT_ERR;
                            end else begin
                                emit_status = ST_REDUCE;
                            end
                        end
                        default: emit_status = ST_ACT_ERR;
                    endcase
                end
                if (emit_status == ST_REDUCE) begin
                    n_tgt   = act_tgt;
                    n_state = S_PROD_RD;
                end else if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (emit_status == ST_SHIFT) begin
                        st_we    = 1'b1;
                        st_wdata = act_tgt;
                        n_top    = act_tgt;
                        n_sp     = r_sp + 1'b1;
                    end else begin
                        n_halted = 1'b1;
                    end
                end
            end
            S_PROD_RD: begin
                n_state = S_PROD;
            end
            S_PROD: begin
                if (CMP_W'(prod_entry[3:0]) >= CMP_W'(r_sp)) begin
                    if (slot_free) begin
                        emit        = 1'b1;
                        emit_status = ST_GOTO_ERR;
                        emit_prod   = 1'b1;
                        n_halted    = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_sp    = r_sp - SP_W'(prod_entry[3:0]);
                    n_lhs   = prod_entry[7:4];
                    n_state = S_POP_RD;
                end
            end
            S_POP_RD: begin
                n_state = S_POP;
            end
            S_POP: begin
                n_top   = (r_sp == SP_W'(1)) ? 6'd0 : st_rdata;
                n_state = S_GOTO_RD;
            end
            S_GOTO_RD: begin
                n_state = S_GOTO;
            end
            S_GOTO: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (!goto_entry[6] || (int'(r_lhs) >= NUM_SYMBOLS)
                        || (int'(goto_entry[5:0]) >= NUM_STATES)) begin
                        emit_status = ST_GOTO_ERR;
                        emit_prod   = 1'b1;
                        n_halted    = 1'b1;
                    end else if (r_sp == SP_FULL) begin
                        emit_status = ST_OVERFLOW;
                        n_halted    = 1'b1;
                    end else begin
                        emit_status = ST_REDUCE;
                        emit_prod   = 1'b1;
                        emit_last   = 1'b0;
                        st_we       = 1'b1;
                        st_wdata    = goto_entry[5:0];
                        n_top       = goto_entry[5:0];
                        n_sp        = r_sp + 1'b1;
                        n_reduces   = r_reduces + 1'b1;
                        n_state     = S_ACT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_prod   = r_out_prod;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = emit_status;
            n_out_prod   = emit_prod ? r_tgt[4:0] : 5'd0;
            n_out_top    = n_top;
            n_out_depth  = 7'(n_sp);
            n_out_last   = emit_last;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_reduced_production = r_out_prod;
    assign o_new_top_state      = r_out_top;
    assign o_stack_depth        = r_out_depth;
    assign o_last               = r_out_last;

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_stall))
        else $error("word emitted over an unaccepted result");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp != '0) && (int'(r_sp) <= STACK_DEPTH))
        else $error("stack pointer out of range");

    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_busy |-> (r_state == S_IDLE))
        else $error("token run during table sweep");

    a_not_last_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !emit_last) |-> (emit_status == ST_REDUCE && n_state == S_ACT_RD))
        else $error("non-final word that is not a reduce");

    a_halt_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_status != ST_SHIFT && emit_status != ST_REDUCE) |=> r_halted)
        else $error("engine not halted after accept or error");

endmodule

// ===== dv/lrsr_parse_checker.sv =====
`timescale 1ns / 1ps
// result checker of the lr shift-reduce parse engine: tracks the tables and stack, predicts every word
module lrsr_parse_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_word_valid,
    input  logic       i_word_stall,
    input  logic [2:0] i_kind,
    input  logic [5:0] i_row_state,
    input  logic [3:0] i_column_symbol,
    input  logic [1:0] i_action_code,
    input  logic [5:0] i_entry_target,
    input  logic       i_goto_valid,
    input  logic [4:0] i_prod_number,
    input  logic [3:0] i_prod_lhs,
    input  logic [3:0] i_prod_length,
    input  logic [3:0] i_token,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [2:0] i_status,
    input  logic [4:0] i_reduced_production,
    input  logic [5:0] i_new_top_state,
    input  logic [6:0] i_stack_depth,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);
    import lrsr_pkg::*;

    localparam int N_RULES    = 32;
    localparam int STACK_SIZE = 64;
    localparam int TABLE_SIZE = 1024;

    typedef struct {
        t_status    status;
        logic [4:0] prod;
        logic [5:0] top;
        logic [6:0] depth;
        logic       last;
    } t_parse_result;

    logic [7:0] action_mem [TABLE_SIZE];
    logic [6:0] goto_mem [TABLE_SIZE];
    logic [7:0] rule_mem [N_RULES];
    logic [5:0] stack_mem [STACK_SIZE];
    int         stack_count;
    logic       parser_halted;
    int         fails;

    t_parse_result predicted_words [$];

    task automatic report_mismatch(string msg);
        fails++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic void push_result(t_status s, logic [4:0] p, logic l);
        t_parse_result r;
        r.status = s;
        r.prod   = p;
        r.top    = stack_mem[stack_count - 1];
        r.depth  = stack_count[6:0];
        r.last   = l;
        predicted_words.insert(predicted_words.size(), r);
    endfunction

    function automatic void end_run(t_status s, logic [4:0] p);
        parser_halted = 1'b1;
        push_result(s, p, 1'b1);
    endfunction

    function automatic void run_token(logic [3:0] tok);
        logic [7:0] entry;
        logic [5:0] tgt;
        logic [7:0] rule;
        logic [6:0] gentry;
        int         nred;
        bit         busy;
        if (parser_halted) begin
            push_result(ST_HALTED, '0, 1'b1);
            return;
        end
        nred = 0;
        busy = 1'b1;
        while (busy) begin
            entry = action_mem[{stack_mem[stack_count - 1], tok}];
            tgt   = entry[5:0];
            busy  = 1'b0;
            case (t_act'(entry[7:6]))
                A_ERROR: end_run(ST_ACT_ERR, '0);
                A_ACCEPT: end_run(ST_ACCEPT, '0);
                A_SHIFT: begin
                    if (stack_count >= STACK_SIZE) begin
                        end_run(ST_OVERFLOW, '0);
                    end else begin
                        stack_mem[stack_count] = tgt;
                        stack_count++;
                        push_result(ST_SHIFT, '0, 1'b1);
                    end
                end
                default: begin
                    rule = rule_mem[tgt[4:0]];
                    if (nred >= int'(CHAIN_LIMIT)) begin
                        end_run(ST_LIMIT, '0);
                    end else if (tgt >= N_RULES) begin
                        end_run(ST_ACT_ERR, '0);
                    end else if (rule[3:0] >= stack_count) begin
                        end_run(ST_GOTO_ERR, tgt[4:0]);
                    end else begin
                        stack_count -= rule[3:0];
                        gentry = goto_mem[{stack_mem[stack_count - 1], rule[7:4]}];
                        if (!gentry[6]) begin
                            end_run(ST_GOTO_ERR, tgt[4:0]);
                        end else if (stack_count >= STACK_SIZE) begin
                            end_run(ST_OVERFLOW, '0);
                        end else begin
                            stack_mem[stack_count] = gentry[5:0];
                            stack_count++;
                            push_result(ST_REDUCE, tgt[4:0], 1'b0);
                            nred++;
                            busy = 1'b1;
                        end
                    end
                end
            endcase
        end
    endfunction

    function automatic void absorb_word();
        case (i_kind)
            K_LOAD_ACT: action_mem[{i_row_state, i_column_symbol}] = {i_action_code, i_entry_target};
            K_LOAD_GOTO: goto_mem[{i_row_state, i_column_symbol}] = {i_goto_valid, i_entry_target};
            K_LOAD_PROD: rule_mem[i_prod_number] = {i_prod_lhs, i_prod_length};
            K_TOKEN: run_token(i_token);
            K_RESTART: begin
                stack_mem[0]  = '0;
                stack_count   = 1;
                parser_halted = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic check_result();
        t_parse_result want;
        if (predicted_words.size() == 0) begin
            report_mismatch($sformatf("result word with none predicted, status %0d", i_status));
        end else begin
            want = predicted_words.pop_front();
            check_field("status", i_status, want.status);
            check_field("reduced_production", i_reduced_production, want.prod);
            check_field("new_top_state", i_new_top_state, want.top);
            check_field("stack_depth", i_stack_depth, want.depth);
            check_field("last", i_last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_SIZE; k++) begin
                action_mem[k] = '0;
                goto_mem[k]   = '0;
            end
            for (int k = 0; k < N_RULES; k++)
                rule_mem[k] = '0;
            for (int k = 0; k < STACK_SIZE; k++)
                stack_mem[k] = '0;
            stack_count   = 1;
            parser_halted = 1'b0;
            fails         = 0;
            predicted_words.delete();
        end else begin
            if (i_word_valid && !i_word_stall)
                absorb_word();
            if (i_res_valid && !i_res_stall)
                check_result();
        end
        o_pending    <= predicted_words.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_lr_shift_reduce_parse_engine.sv =====
`timescale 1ns / 1ps
// testbench top of the lr shift-reduce parse engine: stimulus, handshake pressure and verdict
module tb_lr_shift_reduce_parse_engine;
    import lrsr_pkg::*;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         IDLE_PCT       = 37;
    localparam int         ITEM_TARGET    = 450;
    localparam int         TOKENS_PER_SET = 40;
    localparam logic [2:0] K_SPARE_HI     = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] row;
        logic [3:0] col;
        logic [1:0] code;
        logic [5:0] target;
        logic       gvalid;
        logic [4:0] pnum;
        logic [3:0] lhs;
        logic [3:0] len;
        logic [3:0] tok;
    } t_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [2:0] i_kind;
    logic [5:0] i_row_state;
    logic [3:0] i_column_symbol;
    logic [1:0] i_action_code;
    logic [5:0] i_entry_target;
    logic       i_goto_valid;
    logic [4:0] i_prod_number;
    logic [3:0] i_prod_lhs;
    logic [3:0] i_prod_length;
    logic [3:0] i_token;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_status;
    logic [4:0] o_reduced_production;
    logic [5:0] o_new_top_state;
    logic [6:0] o_stack_depth;
    logic       o_last;

    int         fail_count;
    int         pending;
    int         n_sent;
    bit         quiet;

    lr_shift_reduce_parse_engine dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_kind               (i_kind),
        .i_row_state          (i_row_state),
        .i_column_symbol      (i_column_symbol),
        .i_action_code        (i_action_code),
        .i_entry_target       (i_entry_target),
        .i_goto_valid         (i_goto_valid),
        .i_prod_number        (i_prod_number),
        .i_prod_lhs           (i_prod_lhs),
        .i_prod_length        (i_prod_length),
        .i_token              (i_token),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_reduced_production (o_reduced_production),
        .o_new_top_state      (o_new_top_state),
        .o_stack_depth        (o_stack_depth),
        .o_last               (o_last)
    );

    lrsr_parse_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_word_valid         (i_valid),
        .i_word_stall         (o_stall),
        .i_kind               (i_kind),
        .i_row_state          (i_row_state),
        .i_column_symbol      (i_column_symbol),
        .i_action_code        (i_action_code),
        .i_entry_target       (i_entry_target),
        .i_goto_valid         (i_goto_valid),
        .i_prod_number        (i_prod_number),
        .i_prod_lhs           (i_prod_lhs),
        .i_prod_length        (i_prod_length),
        .i_token              (i_token),
        .i_res_valid          (o_valid),
        .i_res_stall          (i_stall),
        .i_status             (o_status),
        .i_reduced_production (o_reduced_production),
        .i_new_top_state      (o_new_top_state),
        .i_stack_depth        (o_stack_depth),
        .i_last               (o_last),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic t_word noise_word();
        t_word w;
        w.kind   = 3'($urandom_range(0, 7));
        w.row    = 6'($urandom_range(0, 63));
        w.col    = 4'($urandom_range(0, 15));
        w.code   = 2'($urandom_range(0, 3));
        w.target = 6'($urandom_range(0, 63));
        w.gvalid = 1'($urandom_range(0, 1));
        w.pnum   = 5'($urandom_range(0, 31));
        w.lhs    = 4'($urandom_range(0, 15));
        w.len    = 4'($urandom_range(0, 15));
        w.tok    = 4'($urandom_range(0, 15));
        return w;
    endfunction

    function automatic logic [3:0] short_len();
        if ($urandom_range(0, 99) < 85)
            return 4'($urandom_range(0, 2));
        return 4'($urandom_range(0, 15));
    endfunction

    // entered and left just after a falling edge
    task automatic send_word(input t_word w);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= w.kind;
        i_row_state     <= w.row;
        i_column_symbol <= w.col;
        i_action_code   <= w.code;
        i_entry_target  <= w.target;
        i_goto_valid    <= w.gvalid;
        i_prod_number   <= w.pnum;
        i_prod_lhs      <= w.lhs;
        i_prod_length   <= w.len;
        i_token         <= w.tok;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic load_action(logic [5:0] row, logic [3:0] col, t_act code, logic [5:0] tgt);
        t_word w;
        w        = noise_word();
        w.kind   = K_LOAD_ACT;
        w.row    = row;
        w.col    = col;
        w.code   = code;
        w.target = tgt;
        send_word(w);
    endtask

    task automatic load_goto(logic [5:0] row, logic [3:0] col, logic gv, logic [5:0] tgt);
        t_word w;
        w        = noise_word();
        w.kind   = K_LOAD_GOTO;
        w.row    = row;
        w.col    = col;
        w.gvalid = gv;
        w.target = tgt;
        send_word(w);
    endtask

    task automatic load_rule(logic [4:0] p, logic [3:0] lhs, logic [3:0] len);
        t_word w;
        w      = noise_word();
        w.kind = K_LOAD_PROD;
        w.pnum = p;
        w.lhs  = lhs;
        w.len  = len;
        send_word(w);
    endtask

    task automatic send_token(logic [3:0] tok);
        t_word w;
        w      = noise_word();
        w.kind = K_TOKEN;
        w.tok  = tok;
        send_word(w);
    endtask

    task automatic send_restart();
        t_word w;
        w      = noise_word();
        w.kind = K_RESTART;
        send_word(w);
    endtask

    task automatic send_spare();
        t_word w;
        w      = noise_word();
        w.kind = K_SPARE_HI;
        send_word(w);
    endtask

    initial begin
        int         stuck;
        @(posedge i_rst_n);
        stuck = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                stuck = 0;
            else
                stuck++;
            if (stuck >= WATCHDOG_LIMIT)
                break;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [5:0] st [4];
        logic [3:0] alpha [4];
        logic [4:0] rules [4];
        logic [3:0] rlhs [4];
        int         r;
        int         epoch;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_kind          = '0;
        i_row_state     = '0;
        i_column_symbol = '0;
        i_action_code   = '0;
        i_entry_target  = '0;
        i_goto_valid    = 1'b0;
        i_prod_number   = '0;
        i_prod_lhs      = '0;
        i_prod_length   = '0;
        i_token         = '0;
        quiet           = 1'b0;
        n_sent          = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unwritten entry, then token while halted
        send_token(4'd0);
        send_token(4'd15);
        send_restart();
        load_rule(5'd0, 4'd15, 4'd1);
        load_rule(5'd31, 4'd0, 4'd15);
        // self-feeding reduce chain runs into the reduce cap
        load_action(6'd0, 4'd3, A_SHIFT, 6'd63);
        load_action(6'd63, 4'd15, A_REDUCE, 6'd0);
        load_goto(6'd0, 4'd15, 1'b1, 6'd63);
        send_token(4'd3);
        send_token(4'd15);
        send_restart();
        // reduce longer than the stack
        load_action(6'd0, 4'd15, A_REDUCE, 6'd31);
        send_token(4'd15);
        send_restart();
        // reduce by a production number out of range
        load_action(6'd0, 4'd1, A_REDUCE, 6'd40);
        send_token(4'd1);
        send_restart();
        load_action(6'd0, 4'd2, A_ACCEPT, 6'($urandom_range(0, 63)));
        send_token(4'd2);
        send_restart();
        // missing goto leaves the stack popped
        load_goto(6'd0, 4'd15, 1'b0, 6'd63);
        load_action(6'd63, 4'd14, A_REDUCE, 6'd0);
        send_token(4'd3);
        send_token(4'd14);
        send_restart();
        // empty production feeding itself fills the stack
        load_rule(5'd1, 4'd5, 4'd0);
        load_action(6'd63, 4'd13, A_REDUCE, 6'd1);
        load_goto(6'd63, 4'd5, 1'b1, 6'd63);
        send_token(4'd3);
        send_token(4'd13);
        send_spare();
        send_restart();

        for (int p = 0; p < 32; p++)
            load_rule(p[4:0], 4'($urandom_range(0, 15)), short_len());

        epoch = 0;
        while (n_sent < ITEM_TARGET) begin
            quiet = (epoch == 2);
            st[0] = '0;
            for (int i = 1; i < 4; i++)
                st[i] = 6'($urandom_range(0, 63));
            for (int i = 0; i < 4; i++) begin
                alpha[i] = 4'($urandom_range(0, 15));
                rules[i] = 5'($urandom_range(0, 31));
                rlhs[i]  = 4'($urandom_range(0, 15));
                load_rule(rules[i], rlhs[i], short_len());
            end
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        load_action(st[i], alpha[j], A_SHIFT, st[$urandom_range(0, 3)]);
                    else if (r < 80)
                        load_action(st[i], alpha[j], A_REDUCE, {1'b0, rules[$urandom_range(0, 3)]});
                    else if (r < 86)
                        load_action(st[i], alpha[j], A_ACCEPT, 6'($urandom_range(0, 63)));
                    else if (r < 93)
                        load_action(st[i], alpha[j], A_ERROR, 6'($urandom_range(0, 63)));
                    else
                        load_action(st[i], alpha[j], A_REDUCE, 6'($urandom_range(32, 63)));
                end
            end
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    if ($urandom_range(0, 99) < 90)
                        load_goto(st[i], rlhs[j], 1'b1, st[$urandom_range(0, 3)]);
                    else
                        load_goto(st[i], rlhs[j], 1'b0, 6'($urandom_range(0, 63)));
                end
            end
            send_restart();
            repeat (TOKENS_PER_SET) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_restart();
                else if (r < 13)
                    send_word(noise_word());
                else if (r < 93)
                    send_token(alpha[$urandom_range(0, 3)]);
                else
                    send_token(4'($urandom_range(0, 15)));
            end
            epoch++;
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
